### rtl/core/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers for the mixer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous active-low reset masking.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

### rtl/core/amm_pkg.sv
// amm_pkg: shared types and constants of the audio matrix mixer.
// No dependencies; used by amm_ctrl, amm_cell and the top level.
package amm_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int SOURCES_DEF  = 2;

  localparam int SAMPLE_W  = 32;
  localparam int ACC_W     = 37;
  localparam int CH_W      = 3;
  localparam int IDX_W     = 7;
  // row select wide enough for SOURCES*CHANNELS up to 64
  localparam int ROW_MAX_W = 6;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

  typedef enum logic [0:0] {
    OP_MIX   = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic                       operation;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample_a;
    logic signed [SAMPLE_W-1:0] sample_b;
    logic                       a_present;
    logic                       b_present;
    logic [IDX_W-1:0]           gain_index;
    logic signed [SAMPLE_W-1:0] gain_value;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       last;
  } out_item_t;

  // Broadcast from the sequencer to every cell, once per phase.
  typedef struct packed {
    logic                       mul_v;
    logic                       fe;
    logic [ROW_MAX_W-1:0]       row;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_idx;
    logic signed [SAMPLE_W-1:0] wr_val;
  } cell_ctl_t;

endpackage

### rtl/core/audio_matrix_mixer_16x8.sv
// Audio matrix mixer: two CHANNELS-wide Q1.31 sources into one sink through
// a (SOURCES*CHANNELS) x CHANNELS gain table. Depends on amm_pkg, amm_ctrl, amm_cell.
//
// Input channel (in_valid/in_stall/in_data): a write item updates one gain.
// A mix item carries both samples of one input channel and takes one
// phase per source through one multiplier in each output cell; items are
// taken back to back at that pace. Channels out of range are dropped.
// Output channel (out_valid/out_stall/out_data): the mix item of the last
// input channel closes the frame. The CHANNELS saturated results are loaded
// into the cell shift chain after that item's last phase passes the operand
// and product registers, and leave through cell 0, one per cycle, output
// channel 0 first, last set on the final one; out_stall high holds the chain.
// A frame-closing item is held off (in_stall) until the previous frame's
// results have all left; other items keep flowing meanwhile.
// Reset (rst_n low, synchronous) restores the identity gains (source A
// diagonal at full scale, source B muted) and clears the accumulators.
module audio_matrix_mixer_16x8 #(
  parameter int CHANNELS = amm_pkg::CHANNELS_DEF,
  parameter int SOURCES  = amm_pkg::SOURCES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  amm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output amm_pkg::out_item_t out_data
);
  import amm_pkg::*;

  cell_ctl_t     ctl;
  logic [CHANNELS-1:0] sh_v;
  out_item_t     sh_d [CHANNELS];
  logic          adv, chain_busy;

  assign adv        = !(sh_v[0] && out_stall);
  assign chain_busy = |sh_v;

  amm_ctrl #(
    .CHANNELS (CHANNELS),
    .SOURCES  (SOURCES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .chain_busy (chain_busy),
    .ctl        (ctl)
  );

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    logic      nb_v;
    out_item_t nb_d;

    if (g == CHANNELS - 1) begin : g_tail
      assign nb_v = 1'b0;
      assign nb_d = '0;
    end else begin : g_link
      assign nb_v = sh_v[g+1];
      assign nb_d = sh_d[g+1];
    end

    amm_cell #(
      .CHANNELS (CHANNELS),
      .SOURCES  (SOURCES),
      .J        (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .adv   (adv),
      .nb_v  (nb_v),
      .nb_d  (nb_d),
      .sh_v  (sh_v[g]),
      .sh_d  (sh_d[g])
    );
  end

  assign out_valid = sh_v[0];
  assign out_data  = sh_d[0];

endmodule

### rtl/core/amm_ctrl.sv
// amm_ctrl: input register and phase sequencer of the mixer.
// Depends on amm_pkg and assert_macros.svh; drives the cell row.
`include "assert_macros.svh"

module amm_ctrl #(
  parameter int CHANNELS = amm_pkg::CHANNELS_DEF,
  parameter int SOURCES  = amm_pkg::SOURCES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  amm_pkg::in_item_t   in_data,
  input  logic                chain_busy,
  output amm_pkg::cell_ctl_t  ctl
);
  import amm_pkg::*;

  // one multiply phase per source, capped at two
  localparam int NPH = (SOURCES > 1) ? 2 : 1;

  in_item_t   itm_r;
  logic       itm_v_r, itm_v_nxt;
  logic       ph_r, ph_nxt;
  logic [1:0] fe_d_r, fe_d_nxt;

  logic is_wr, ch_ok, mix_w, last_ph, done, itm_fe, in_fe, fe_pend, acc_w;

  assign is_wr   = (itm_r.operation == OP_WRITE);
  assign ch_ok   = (int'(itm_r.channel) < CHANNELS);
  assign mix_w   = !is_wr && ch_ok;
  assign last_ph = (ph_r == 1'(NPH - 1));
  assign done    = !mix_w || last_ph;
  assign itm_fe  = mix_w && (int'(itm_r.channel) == CHANNELS - 1);
  assign in_fe   = (in_data.operation == OP_MIX) &&
                   (int'(in_data.channel) == CHANNELS - 1);
  // a frame end may only enter once the result chain is free for it
  assign fe_pend  = (itm_v_r && itm_fe) || (|fe_d_r);
  assign in_stall = (itm_v_r && !done) ||
                    (in_valid && in_fe && (fe_pend || chain_busy));
  assign acc_w    = in_valid && !in_stall;

  always_comb begin
    ctl.mul_v  = itm_v_r && mix_w;
    ctl.fe     = itm_v_r && itm_fe && last_ph;
    ctl.row    = ROW_MAX_W'(int'(ph_r) * CHANNELS + int'(itm_r.channel));
    if (ph_r) begin
      ctl.sample = itm_r.b_present ? itm_r.sample_b : '0;
    end else begin
      ctl.sample = itm_r.a_present ? itm_r.sample_a : '0;
    end
    ctl.wr_en  = itm_v_r && is_wr;
    ctl.wr_idx = itm_r.gain_index;
    ctl.wr_val = itm_r.gain_value;
  end

  always_comb begin
    itm_v_nxt = itm_v_r;
    ph_nxt    = ph_r;
    if (acc_w) begin
      itm_v_nxt = 1'b1;
      ph_nxt    = 1'b0;
    end else if (itm_v_r && done) begin
      itm_v_nxt = 1'b0;
      ph_nxt    = 1'b0;
    end else if (itm_v_r) begin
      ph_nxt = 1'b1;
    end
    fe_d_nxt = {fe_d_r[0], ctl.fe};
  end

  always_ff @(posedge clk) begin
    if (acc_w) begin
      itm_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itm_v_r <= 1'b0;
      ph_r    <= 1'b0;
      fe_d_r  <= '0;
    end else begin
      itm_v_r <= itm_v_nxt;
      ph_r    <= ph_nxt;
      fe_d_r  <= fe_d_nxt;
    end
  end

  `ASSERT_CLK(a_second_phase_mix, clk, rst_n, (itm_v_r && ph_r) |-> mix_w, "B phase on a non-mix item")
  `ASSERT_CLK(a_frame_end_gap, clk, rst_n, ctl.fe |=> !ctl.fe, "frame ends in back-to-back cycles")

endmodule

### rtl/core/amm_cell.sv
// amm_cell: one output channel: gain column, multiplier, accumulator and
// one stage of the result shift chain. Depends on amm_pkg, assert_macros.svh.
`include "assert_macros.svh"

module amm_cell #(
  parameter int CHANNELS = amm_pkg::CHANNELS_DEF,
  parameter int SOURCES  = amm_pkg::SOURCES_DEF,
  parameter int J        = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  amm_pkg::cell_ctl_t  ctl,
  input  logic                adv,
  input  logic                nb_v,
  input  amm_pkg::out_item_t  nb_d,
  output logic                sh_v,
  output amm_pkg::out_item_t  sh_d
);
  import amm_pkg::*;

  localparam int ROWS  = SOURCES * CHANNELS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic signed [SAMPLE_W-1:0]   tbl_r [ROWS];
  logic signed [SAMPLE_W-1:0]   op_s_r, op_g_r;
  logic                         v1_r, fe1_r, v2_r, fe2_r;
  logic signed [2*SAMPLE_W-1:0] prod_r, mul_w;
  logic signed [ACC_W-1:0]      acc_r, acc_nxt, q_w, sum_w;
  logic signed [SAMPLE_W-1:0]   sat_w;
  logic                         load_w;
  logic                         sh_v_r, sh_v_nxt;
  out_item_t                    sh_d_r, sh_d_nxt, own_w;

  // gain rows: row = source*CHANNELS + input channel; reset is identity on A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        tbl_r[r] <= (r == J) ? SAMPLE_MAX : '0;
      end
    end else if (ctl.wr_en) begin
      for (int r = 0; r < ROWS; r++) begin
        if (int'(ctl.wr_idx) == r * CHANNELS + J) begin
          tbl_r[r] <= ctl.wr_val;
        end
      end
    end
  end

  assign mul_w = op_s_r * op_g_r;

  // floor(p / 2^31) of the product, sign-extended into the accumulator
  assign q_w   = {{(ACC_W - SAMPLE_W - 1){prod_r[2*SAMPLE_W-1]}},
                  prod_r[2*SAMPLE_W-1:SAMPLE_W-1]};
  assign sum_w = acc_r + q_w;

  always_comb begin
    if (sum_w[ACC_W-1:SAMPLE_W-1] == {(ACC_W - SAMPLE_W + 1){sum_w[SAMPLE_W-1]}}) begin
      sat_w = sum_w[SAMPLE_W-1:0];
    end else begin
      sat_w = sum_w[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end
  end

  assign load_w = v2_r && fe2_r;

  always_comb begin
    acc_nxt = acc_r;
    if (v2_r) begin
      acc_nxt = fe2_r ? '0 : sum_w;
    end
  end

  always_comb begin
    own_w.out_channel = CH_W'(J);
    own_w.out_sample  = sat_w;
    own_w.last        = (J == CHANNELS - 1);
    sh_v_nxt = sh_v_r;
    sh_d_nxt = sh_d_r;
    if (load_w) begin
      sh_v_nxt = 1'b1;
      sh_d_nxt = own_w;
    end else if (adv) begin
      sh_v_nxt = nb_v;
      sh_d_nxt = nb_d;
    end
  end

  always_ff @(posedge clk) begin
    op_s_r <= ctl.sample;
    op_g_r <= tbl_r[ctl.row[ROW_W-1:0]];
    prod_r <= mul_w;
    sh_d_r <= sh_d_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      fe1_r  <= 1'b0;
      v2_r   <= 1'b0;
      fe2_r  <= 1'b0;
      acc_r  <= '0;
      sh_v_r <= 1'b0;
    end else begin
      v1_r   <= ctl.mul_v;
      fe1_r  <= ctl.fe;
      v2_r   <= v1_r;
      fe2_r  <= fe1_r;
      acc_r  <= acc_nxt;
      sh_v_r <= sh_v_nxt;
    end
  end

  assign sh_v = sh_v_r;
  assign sh_d = sh_d_r;

  `ASSERT_NEVER(a_load_into_full, clk, rst_n, load_w && sh_v_r, "frame result over a pending one")
  `ASSERT_CLK(a_acc_cleared, clk, rst_n, load_w |=> (acc_r == '0), "accumulator kept after frame end")

endmodule
